>>> rtl/core/vertex_transform_4x4_defines.svh
// Assertion macros for the checker file of the transform block.
`ifndef VERTEX_TRANSFORM_4X4_DEFINES_SVH
`define VERTEX_TRANSFORM_4X4_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VT44_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vertex transform check failed");

// The consequent must hold in the cycle after the antecedent.
`define VT44_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vertex transform check failed");

`endif

>>> rtl/core/vt44_pkg.sv
package vt44_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;
  localparam int VEC_W      = 32;
  localparam int NUM_LANES  = 4;
  localparam int NUM_ELEMS  = NUM_LANES * NUM_LANES;
  localparam int IDX_W      = $clog2(NUM_ELEMS);
  localparam int CMD_W      = 2;
  localparam int PROD_W     = WORD_WIDTH + VEC_W;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int ACC_W      = PROD_W + 2;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [VEC_W-1:0]      vec_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [PAIR_W-1:0]     pair_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD,
    CMD_IDENTITY,
    CMD_TRANSLATE,
    CMD_TRANSFORM
  } cmd_e;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctrl_t;

  // Clamps a wide signed value to the signed range of one matrix element.
  function automatic word_t sat_word(input acc_t v);
    acc_t maxv;
    acc_t minv;
    maxv = acc_t'({1'b0, {(WORD_WIDTH - 1){1'b1}}});
    minv = ~maxv;
    if (v > maxv) begin
      return word_t'(maxv);
    end else if (v < minv) begin
      return word_t'(minv);
    end
    return word_t'(v);
  endfunction

  localparam word_t ONE_Q = sat_word(acc_t'(1) << FRAC_BITS);

endpackage

>>> rtl/core/vt44_matrix.sv
module vt44_matrix (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       upd_i,
  input  vt44_pkg::cmd_e             cmd_i,
  input  logic [vt44_pkg::IDX_W-1:0] idx_i,
  input  vt44_pkg::vec_t             vx_i,
  input  vt44_pkg::vec_t             vy_i,
  input  vt44_pkg::vec_t             vz_i,
  output vt44_pkg::word_t            mat_o [vt44_pkg::NUM_ELEMS]
);
  import vt44_pkg::*;

  word_t mat_q [NUM_ELEMS];
  word_t mat_d [NUM_ELEMS];
  vec_t  tv    [NUM_LANES-1];

  always_comb begin
    tv[0] = vx_i;
    tv[1] = vy_i;
    tv[2] = vz_i;
    mat_d = mat_q;
    if (upd_i) begin
      unique case (cmd_i)
        CMD_LOAD: begin
          mat_d[idx_i] = sat_word(acc_t'(vx_i));
        end
        CMD_IDENTITY: begin
          for (int r = 0; r < NUM_LANES; r++) begin
            mat_d[r * NUM_LANES + r] = ONE_Q;
          end
        end
        CMD_TRANSLATE: begin
          // The last column of the first three rows holds the offset.
          for (int r = 0; r < NUM_LANES - 1; r++) begin
            mat_d[r * NUM_LANES + NUM_LANES - 1] =
                sat_word(acc_t'(mat_q[r * NUM_LANES + NUM_LANES - 1]) + acc_t'(tv[r]));
          end
        end
        CMD_TRANSFORM: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ELEMS; i++) begin
        mat_q[i] <= '0;
      end
    end else begin
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

>>> rtl/core/vt44_lane.sv
module vt44_lane (
  input  logic                 clk_i,
  input  vt44_pkg::pipe_ctrl_t ctrl_i,
  input  vt44_pkg::word_t      row_i [vt44_pkg::NUM_LANES],
  input  vt44_pkg::vec_t       vec_i [vt44_pkg::NUM_LANES],
  output vt44_pkg::vec_t       res_o
);
  import vt44_pkg::*;

  prod_t prod_q [NUM_LANES];
  pair_t pair_q [NUM_LANES/2];
  acc_t  acc;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_load) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        prod_q[k] <= $signed(row_i[k]) * $signed(vec_i[k]);
      end
    end
    if (ctrl_i.s2_load) begin
      for (int p = 0; p < NUM_LANES / 2; p++) begin
        pair_q[p] <= pair_t'(prod_q[2 * p]) + pair_t'(prod_q[2 * p + 1]);
      end
    end
  end

  // Exact row sum, then an arithmetic shift that rounds toward minus infinity, then a clamp.
  always_comb begin
    acc   = acc_t'(pair_q[0]) + acc_t'(pair_q[1]);
    res_o = vec_t'(sat_word(acc >>> FRAC_BITS));
  end

endmodule

>>> rtl/core/vertex_transform_4x4.sv
// One word per cycle unless stalled; a transform word passes the product, pair
// sum and output registers. Four row lanes of four 32x32 multipliers each
// run as a three-stage pipeline (products, pair sums, final sum and clamp).
// Load, identity and translate words update the matrix at acceptance, no result.
// Reset clears the matrix to zero and empties the pipeline; no clearing pass.
module vertex_transform_4x4 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [vt44_pkg::CMD_W-1:0] cmd_i,
  input  logic [vt44_pkg::IDX_W-1:0] elem_index_i,
  input  vt44_pkg::vec_t             vx_i,
  input  vt44_pkg::vec_t             vy_i,
  input  vt44_pkg::vec_t             vz_i,
  input  vt44_pkg::vec_t             vw_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output vt44_pkg::vec_t             tx_o,
  output vt44_pkg::vec_t             ty_o,
  output vt44_pkg::vec_t             tz_o,
  output vt44_pkg::vec_t             tw_o
);
  import vt44_pkg::*;

  cmd_e       cmd;
  logic       in_acc;
  logic       xf_acc;
  logic       out_free;
  logic       s2_free;
  logic       s1_free;
  logic       s1_valid_q;
  logic       s2_valid_q;
  logic       out_valid_q;
  pipe_ctrl_t ctrl;
  word_t      mat  [NUM_ELEMS];
  word_t      rows [NUM_LANES][NUM_LANES];
  vec_t       vec  [NUM_LANES];
  vec_t       lane_res [NUM_LANES];
  vec_t       res_q    [NUM_LANES];

  assign cmd = cmd_e'(cmd_i);

  // Each stage moves on when the one after it is empty or moving on itself.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_stall_o = !s1_free;

  assign in_acc = in_valid_i && !in_stall_o;
  assign xf_acc = in_acc && (cmd == CMD_TRANSFORM);

  assign ctrl.s1_load = xf_acc;
  assign ctrl.s2_load = s1_valid_q && s2_free;

  vt44_matrix u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (in_acc && (cmd != CMD_TRANSFORM)),
    .cmd_i  (cmd),
    .idx_i  (elem_index_i),
    .vx_i   (vx_i),
    .vy_i   (vy_i),
    .vz_i   (vz_i),
    .mat_o  (mat)
  );

  always_comb begin
    vec[0] = vx_i;
    vec[1] = vy_i;
    vec[2] = vz_i;
    vec[3] = vw_i;
    for (int r = 0; r < NUM_LANES; r++) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        rows[r][k] = mat[r * NUM_LANES + k];
      end
    end
  end

  for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
    vt44_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .row_i  (rows[r]),
      .vec_i  (vec),
      .res_o  (lane_res[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= xf_acc;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Output register gathers the four lane results into one word.
  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_free) begin
      res_q <= lane_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_o = res_q[0];
  assign ty_o = res_q[1];
  assign tz_o = res_q[2];
  assign tw_o = res_q[3];

endmodule

>>> rtl/core/vt44_checker.sv
`include "vertex_transform_4x4_defines.svh"

module vt44_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [vt44_pkg::CMD_W-1:0] cmd_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input vt44_pkg::vec_t             tx_o,
  input vt44_pkg::vec_t             tw_o
);
  import vt44_pkg::*;

  logic xf_acc;

  assign xf_acc = in_valid_i && !in_stall_o && (cmd_i == CMD_TRANSFORM);

  // A held result word keeps its value until it is taken.
  `VT44_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(tx_o) && $stable(tw_o))

  // With nothing waiting at the output the pipeline cannot be full.
  `VT44_ASSERT_NOW(a_empty_no_stall, !out_valid_o, !in_stall_o)

  // A free output side always lets the input side move.
  `VT44_ASSERT_NOW(a_free_no_stall, !out_stall_i, !in_stall_o)

  // With no output stall after it, an accepted transform passes the product and pair sum stages and reaches the output.
  `VT44_ASSERT_NEXT(a_latency, xf_acc ##1 !out_stall_i ##1 !out_stall_i, out_valid_o)

endmodule

bind vertex_transform_4x4 vt44_checker u_vt44_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .tx_o        (tx_o),
  .tw_o        (tw_o)
);

>>> verif/tb_vertex_transform_4x4.sv
module tb_vertex_transform_4x4;
  import vt44_pkg::*;

  localparam int ACC_BITS = WORD_WIDTH + VEC_W + 4;
  localparam vec_t Q_MAX = 32'sh7FFFFFFF;
  localparam vec_t Q_MIN = 32'sh80000000;
  localparam vec_t Q_ONE = 32'sh00010000;

  typedef logic signed [ACC_BITS-1:0] wide_t;

  typedef struct {
    vec_t x;
    vec_t y;
    vec_t z;
    vec_t w;
  } vertex_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     cmd_i;
  logic [IDX_W-1:0]     elem_index_i;
  vec_t                 vx_i;
  vec_t                 vy_i;
  vec_t                 vz_i;
  vec_t                 vw_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  vec_t                 tx_o;
  vec_t                 ty_o;
  vec_t                 tz_o;
  vec_t                 tw_o;

  word_t   shadow_matrix [NUM_ELEMS];
  vertex_t expected_vertices [$];
  vertex_t due_vertex;
  int      error_count;
  int      words_sent;
  int      vertices_checked;
  int      op_count [4];
  int      stall_left;
  logic    hold_off;
  logic    send_gaps_on;
  logic    stall_bursts_on;

  vertex_transform_4x4 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .elem_index_i (elem_index_i),
    .vx_i         (vx_i),
    .vy_i         (vy_i),
    .vz_i         (vz_i),
    .vw_i         (vw_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_o         (tx_o),
    .ty_o         (ty_o),
    .tz_o         (tz_o),
    .tw_o         (tw_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic word_t clamp_word(input wide_t v);
    wide_t hi_lim;
    wide_t lo_lim;
    hi_lim = (wide_t'(1) <<< (WORD_WIDTH - 1)) - wide_t'(1);
    lo_lim = -hi_lim - wide_t'(1);
    if (v > hi_lim) begin
      return word_t'(hi_lim);
    end else if (v < lo_lim) begin
      return word_t'(lo_lim);
    end
    return word_t'(v);
  endfunction

  // Mirrors the matrix update of one accepted word and queues the product of a
  // transform. Sums are exact at full width, then floored and clamped.
  task automatic apply_word(input cmd_e op, input logic [IDX_W-1:0] idx,
                            input vec_t x, input vec_t y, input vec_t z, input vec_t w);
    vec_t    vin [4];
    vec_t    prod [4];
    wide_t   acc;
    word_t   one_q;
    vertex_t due;
    vin = '{x, y, z, w};
    op_count[op]++;
    case (op)
      CMD_LOAD: shadow_matrix[idx] = clamp_word(wide_t'(x));
      CMD_IDENTITY: begin
        one_q = clamp_word(wide_t'(1) <<< FRAC_BITS);
        for (int d = 0; d < NUM_LANES; d++) shadow_matrix[5 * d] = one_q;
      end
      CMD_TRANSLATE: begin
        for (int r = 0; r < 3; r++) begin
          shadow_matrix[4 * r + 3] =
            clamp_word(wide_t'(shadow_matrix[4 * r + 3]) + wide_t'(vin[r]));
        end
      end
      CMD_TRANSFORM: begin
        for (int r = 0; r < NUM_LANES; r++) begin
          acc = '0;
          for (int k = 0; k < NUM_LANES; k++) begin
            acc = acc + wide_t'(shadow_matrix[4 * r + k]) * wide_t'(vin[k]);
          end
          prod[r] = vec_t'(clamp_word(acc >>> FRAC_BITS));
        end
        due = '{prod[0], prod[1], prod[2], prod[3]};
        expected_vertices.push_back(due);
      end
      default: ;
    endcase
  endtask

  // Mostly values within +/-8.0 so that sums stay in range, with full-range
  // words and the extremes mixed in.
  function automatic vec_t rand_q();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      1, 2, 3: return vec_t'($urandom);
      default: return vec_t'(int'($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000);
    endcase
  endfunction

  task automatic send_word(input cmd_e op, input logic [IDX_W-1:0] idx,
                           input vec_t x, input vec_t y, input vec_t z, input vec_t w);
    int gap;
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    elem_index_i <= idx;
    vx_i         <= x;
    vy_i         <= y;
    vz_i         <= z;
    vw_i         <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_word(op, idx, x, y, z, w);
    words_sent++;
    if (send_gaps_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_word();
    int   pick;
    cmd_e op;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      op = CMD_TRANSFORM;
    end else if (pick < 16) begin
      op = CMD_LOAD;
    end else if (pick < 18) begin
      op = CMD_TRANSLATE;
    end else begin
      op = CMD_IDENTITY;
    end
    send_word(op, IDX_W'($urandom_range(0, NUM_ELEMS - 1)),
              rand_q(), rand_q(), rand_q(), rand_q());
  endtask

  task automatic test_cleared_matrix();
    send_word(CMD_TRANSFORM, '0, Q_MAX, Q_MIN, -32'sd1, 32'sh12345678);
  endtask

  task automatic test_load_extremes();
    send_word(CMD_LOAD, '0, Q_MAX, rand_q(), rand_q(), rand_q());
    send_word(CMD_LOAD, IDX_W'(15), Q_MIN, rand_q(), rand_q(), rand_q());
    send_word(CMD_LOAD, IDX_W'(5), -32'sd1, rand_q(), rand_q(), rand_q());
    send_word(CMD_LOAD, IDX_W'(10), 32'sd1, rand_q(), rand_q(), rand_q());
    // Large products clamp both ways; the raw -1 entries show flooring.
    send_word(CMD_TRANSFORM, '0, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
    send_word(CMD_TRANSFORM, '0, Q_MIN, 32'sd1, -32'sd1, Q_MAX);
  endtask

  task automatic test_identity_translate();
    send_word(CMD_LOAD, '0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_word(CMD_LOAD, IDX_W'(15), 32'sh00030000, 32'sd0, 32'sd0, 32'sd0);
    send_word(CMD_IDENTITY, IDX_W'(7), rand_q(), rand_q(), rand_q(), rand_q());
    send_word(CMD_TRANSFORM, '0, Q_ONE, 32'sh00020000, 32'shFFFF8000, Q_ONE);
    send_word(CMD_TRANSLATE, '0, Q_ONE, -Q_ONE, 32'sh00000001, rand_q());
    send_word(CMD_TRANSFORM, '0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    // Translation that runs off both ends of the element range.
    send_word(CMD_TRANSLATE, '0, Q_MAX, Q_MIN, Q_MAX, rand_q());
    send_word(CMD_TRANSLATE, '0, Q_MAX, Q_MIN, -32'sd1, rand_q());
    send_word(CMD_TRANSFORM, '0, 32'sd1, -32'sd1, Q_MIN, 32'sh00008000);
    send_word(CMD_LOAD, IDX_W'(3), 32'sh00000007, 32'sd0, 32'sd0, 32'sd0);
    send_word(CMD_TRANSFORM, '0, -32'sd3, Q_ONE, 32'sd0, -Q_ONE);
  endtask

  task automatic test_random_stream();
    for (int n = 0; n < 640; n++) send_random_word();
  endtask

  // The output is held off long enough for the pipeline to fill and push
  // back on the input while transform words keep coming.
  task automatic test_output_holdoff();
    send_gaps_on = 1'b0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    for (int n = 0; n < 60; n++) begin
      send_word(CMD_TRANSFORM, IDX_W'($urandom_range(0, NUM_ELEMS - 1)),
                rand_q(), rand_q(), rand_q(), rand_q());
    end
    send_gaps_on = 1'b1;
  endtask

  task automatic test_full_rate();
    send_gaps_on    = 1'b0;
    stall_bursts_on = 1'b0;
    for (int n = 0; n < 100; n++) send_random_word();
  endtask

  // Checks each output word that is taken against the oldest prediction and drives the
  // output stall in random bursts and during the hold-off.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h %h %h %h", tx_o, ty_o, tz_o, tw_o));
      end else begin
        due_vertex = expected_vertices.pop_front();
        vertices_checked++;
        if (tx_o !== due_vertex.x) report_mismatch($sformatf("tx %h, want %h", tx_o, due_vertex.x));
        if (ty_o !== due_vertex.y) report_mismatch($sformatf("ty %h, want %h", ty_o, due_vertex.y));
        if (tz_o !== due_vertex.z) report_mismatch($sformatf("tz %h, want %h", tz_o, due_vertex.z));
        if (tw_o !== due_vertex.w) report_mismatch($sformatf("tw %h, want %h", tw_o, due_vertex.w));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
    end else if (stall_bursts_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 14);
    end
    out_stall_i <= hold_off || (stall_left > 0);
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    cmd_i           = CMD_LOAD;
    elem_index_i    = '0;
    vx_i            = '0;
    vy_i            = '0;
    vz_i            = '0;
    vw_i            = '0;
    out_stall_i     = 1'b0;
    hold_off        = 1'b0;
    stall_left      = 0;
    send_gaps_on    = 1'b1;
    stall_bursts_on = 1'b1;
    error_count     = 0;
    words_sent      = 0;
    vertices_checked = 0;
    for (int e = 0; e < NUM_ELEMS; e++) shadow_matrix[e] = '0;
    for (int c = 0; c < 4; c++) op_count[c] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cleared_matrix();
    test_load_extremes();
    test_identity_translate();
    test_random_stream();
    test_output_holdoff();
    test_full_rate();

    in_valid_i <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Sent %0d words: %0d load, %0d identity, %0d translate, %0d transform.",
             words_sent, op_count[CMD_LOAD], op_count[CMD_IDENTITY],
             op_count[CMD_TRANSLATE], op_count[CMD_TRANSFORM]);
    $display("Checked %0d transformed vertices, %0d mismatches.", vertices_checked, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("Timeout with %0d vertices still pending.", expected_vertices.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
